// ===== rtl/core/jump_search_sorted_table_top_macros.svh =====
// Assertion macros shared by the jump search block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef JUMP_SEARCH_SORTED_TABLE_TOP_MACROS_SVH
`define JUMP_SEARCH_SORTED_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/jsst_pkg.sv =====
// Shared types, constants and command/status structs for the jump search block.
// No dependencies; the interface, datapath, controller and top files use this package.
package jsst_pkg;

    // Table value and field widths.
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 10;
    localparam int CFG_W   = 11;
    localparam int CNT_W   = 12;
    localparam int CFG_IDX_W = 2;

    // Table depth default and the reach of entry_index and position.
    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam int REACH_LIMIT = 1024;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] COUNT_RESET  = 11'd0;
    localparam logic [CFG_W-1:0] STRIDE_RESET = 11'd32;

    // Request type codes.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_STRIDE   = 2'd1;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [CFG_W-1:0] cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [CNT_W-1:0] count_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tbl_write;
        logic start_search;
        logic rd_jump;
        logic jump_step;
        logic scan_begin;
        logic rd_scan;
        logic scan_step;
        logic record_hit;
        logic out_load;
    } jsst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic probe_less;
        logic end_past;
        logic scan_end;
        logic scan_eq;
        logic scan_gt;
    } jsst_sts_t;

endpackage

// ===== rtl/core/jsst_if.sv =====
// Valid/ready channel interfaces for search requests and search results.
// Depends on jsst_pkg for the payload types.
interface jsst_req_if;
    logic                valid;
    logic                ready;
    logic                req_type;
    jsst_pkg::index_t    entry_index;
    jsst_pkg::value_t    item_value;

    modport source (output valid, output req_type, output entry_index, output item_value,
                    input ready);
    modport sink (input valid, input req_type, input entry_index, input item_value,
                  output ready);
endinterface

interface jsst_res_if;
    logic                valid;
    logic                ready;
    logic                found;
    jsst_pkg::index_t    position;

    modport source (output valid, output found, output position, input ready);
    modport sink (input valid, input found, input position, output ready);
endinterface

// ===== rtl/core/jsst_datapath.sv =====
// Datapath of the jump search block: table memory, configuration registers,
// search bounds, probe compare and result registers. Depends on jsst_pkg.
module jsst_datapath #(
    parameter int TABLE_DEPTH = jsst_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jsst_pkg::jsst_cmd_t   cmd,
    output jsst_pkg::jsst_sts_t   sts,
    input  logic                  cfg_we,
    input  jsst_pkg::cfg_index_t  cfg_index,
    input  jsst_pkg::cfg_data_t   cfg_wdata,
    input  jsst_pkg::index_t      entry_index,
    input  jsst_pkg::value_t      item_value,
    output logic                  found,
    output jsst_pkg::index_t      position
);
    import jsst_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LIMIT_INT = (TABLE_DEPTH < REACH_LIMIT) ? TABLE_DEPTH : REACH_LIMIT;
    localparam count_t LIMIT = CNT_W'(LIMIT_INT);

    value_t           tbl_mem [TABLE_DEPTH];
    value_t           rd_data_reg;
    value_t           key_reg;
    cfg_data_t        count_reg;
    cfg_data_t        stride_reg;
    count_t           start_reg;
    count_t           start_next;
    count_t           end_reg;
    count_t           end_next;
    logic             hit_reg;
    logic             hit_next;
    index_t           hit_pos_reg;
    index_t           hit_pos_next;
    logic             out_found_reg;
    index_t           out_pos_reg;

    count_t           n_clip;
    count_t           stride_eff;
    count_t           end_clip;
    count_t           jump_addr;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;

    // Used length and effective stride.
    always_comb
    begin
        n_clip = ({1'b0, count_reg} < LIMIT) ? {1'b0, count_reg} : LIMIT;
        stride_eff = (stride_reg == '0) ? count_t'(1) : {1'b0, stride_reg};
        end_clip = (end_reg < n_clip) ? end_reg : n_clip;
        jump_addr = end_clip - count_t'(1);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= COUNT_RESET;
            stride_reg <= STRIDE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ELEMENT_COUNT: count_reg  <= cfg_wdata;
                CFG_JUMP_STRIDE:   stride_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Table memory: one write port, one registered read port.
    assign wr_en = cmd.tbl_write && (int'(entry_index) < TABLE_DEPTH);
    assign rd_addr = cmd.rd_jump ? AW'(jump_addr) : AW'(start_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[AW'(entry_index)] <= item_value;
        end
        if (cmd.rd_jump || cmd.rd_scan)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    // Search bounds and hit tracking.
    always_comb
    begin
        start_next   = start_reg;
        end_next     = end_reg;
        hit_next     = hit_reg;
        hit_pos_next = hit_pos_reg;
        if (cmd.start_search)
        begin
            start_next   = '0;
            end_next     = stride_eff;
            hit_next     = 1'b0;
            hit_pos_next = '0;
        end
        else if (cmd.jump_step)
        begin
            start_next = end_reg;
            end_next   = end_reg + stride_eff;
        end
        else if (cmd.scan_begin)
        begin
            end_next = end_clip;
        end
        else if (cmd.scan_step)
        begin
            start_next = start_reg + count_t'(1);
        end
        else if (cmd.record_hit)
        begin
            hit_next     = 1'b1;
            hit_pos_next = start_reg[INDEX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_search)
        begin
            key_reg <= item_value;
        end
        start_reg   <= start_next;
        end_reg     <= end_next;
        hit_reg     <= hit_next;
        hit_pos_reg <= hit_pos_next;
    end

    // Result register facing the output channel.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= hit_reg;
            out_pos_reg   <= hit_pos_reg;
        end
    end

    assign found    = out_found_reg;
    assign position = out_pos_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.n_zero     = (n_clip == '0);
        sts.probe_less = (rd_data_reg < key_reg);
        sts.end_past   = (end_reg >= n_clip);
        sts.scan_end   = (start_reg >= end_reg);
        sts.scan_eq    = (rd_data_reg == key_reg);
        sts.scan_gt    = (rd_data_reg > key_reg);
    end

endmodule

// ===== rtl/core/jsst_ctrl.sv =====
// Controller of the jump search block: one-hot state machine that sequences
// jump probes, the in-block scan and the result handoff. Depends on jsst_pkg.
module jsst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_type,
    output logic                 req_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  jsst_pkg::jsst_sts_t  sts,
    output jsst_pkg::jsst_cmd_t  cmd
);
    import jsst_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_JUMP_RD  = 6'b000010,
        ST_JUMP_CMP = 6'b000100,
        ST_SCAN_RD  = 6'b001000,
        ST_SCAN_CMP = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.tbl_write    = accept && (req_type == REQ_WRITE);
        cmd.start_search = accept && (req_type == REQ_SEARCH);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start_search)
                begin
                    state_next = sts.n_zero ? ST_DONE : ST_JUMP_RD;
                end
            end
            ST_JUMP_RD:
            begin
                cmd.rd_jump = 1'b1;
                state_next  = ST_JUMP_CMP;
            end
            ST_JUMP_CMP:
            begin
                if (sts.probe_less)
                begin
                    cmd.jump_step = 1'b1;
                    state_next = sts.end_past ? ST_DONE : ST_JUMP_RD;
                end
                else
                begin
                    cmd.scan_begin = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (sts.scan_eq)
                begin
                    cmd.record_hit = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.scan_gt)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid holds until the result request is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/jump_search_sorted_table_top.sv =====
// Jump search over a sorted table. Write requests are taken in the idle state
// and can follow back to back. A search reads and compares a jump probe at each
// block end, then reads and compares each scanned entry, since the single table
// read port is registered; setup and result handoff come around these steps.
// The result sits in an output register, so the next request is taken meanwhile.
// Reset clears control, count to 0 and stride to 32; table contents are kept.
`include "jump_search_sorted_table_top_macros.svh"

module jump_search_sorted_table_top #(
    parameter int TABLE_DEPTH = jsst_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    jsst_req_if.sink              req,
    jsst_res_if.source            res,
    input  logic                  cfg_we,
    input  jsst_pkg::cfg_index_t  cfg_index,
    input  jsst_pkg::cfg_data_t   cfg_wdata
);
    import jsst_pkg::*;

    jsst_cmd_t cmd;
    jsst_sts_t sts;

    // Sequencer.
    jsst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table, bounds and compare.
    jsst_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .entry_index (req.entry_index),
        .item_value  (req.item_value),
        .found       (res.found),
        .position    (res.position)
    );

    // A search keeps the input side busy in the following cycle.
    `JSST_ASSERT_NEXT(a_search_busy, req.valid && req.ready && (req.req_type == REQ_SEARCH), !req.ready, "input still ready after a search was accepted")
    // The result register is only loaded into a free or draining slot.
    `JSST_ASSERT_NOW(a_load_slot_free, cmd.out_load, !res.valid || res.ready, "result overwritten before it was taken")
    // A hit is only recorded on an equal compare.
    `JSST_ASSERT_NOW(a_hit_on_equal, cmd.record_hit, sts.scan_eq, "hit recorded without a matching entry")
    // A miss reports position zero.
    `JSST_ASSERT_NOW(a_miss_pos_zero, res.valid && !res.found, res.position == '0, "miss with nonzero position")

endmodule

// ===== tb/sv/jsst_tb_pkg.sv =====
// Search-result tracker for the jump search testbench: table image, register copy
// and the queue of search outcomes still owed by the block. Depends on jsst_pkg.
package jsst_tb_pkg;
    import jsst_pkg::*;

    typedef struct {
        logic   found;
        index_t position;
    } search_outcome_t;

    class table_search_tracker;
        value_t          entries [REACH_LIMIT];
        cfg_data_t       element_count;
        cfg_data_t       jump_stride;
        search_outcome_t awaited_results [$];
        int unsigned     errors;

        function new();
            element_count = COUNT_RESET;
            jump_stride   = STRIDE_RESET;
            errors        = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        // Mirror of a configuration write; unknown indexes are dropped.
        function void set_register(cfg_index_t idx, cfg_data_t data);
            case (idx)
                CFG_ELEMENT_COUNT: element_count = data;
                CFG_JUMP_STRIDE:   jump_stride = data;
                default: ;
            endcase
        endfunction

        // Entries in use, clipped to the reach of the index fields.
        function int unsigned used_length();
            return (element_count > REACH_LIMIT) ? REACH_LIMIT : element_count;
        endfunction

        // Jump from block to block until the last used element of a block is not
        // below the key, then scan that block from its start.
        function bit locate_key(value_t key, output index_t pos);
            int unsigned n;
            int unsigned step;
            int unsigned blk_lo;
            int unsigned blk_hi;
            pos = '0;
            n = used_length();
            step = (jump_stride == 0) ? 1 : jump_stride;
            if (n == 0)
                return 1'b0;
            blk_lo = 0;
            blk_hi = step;
            while (entries[((blk_hi < n) ? blk_hi : n) - 1] < key)
            begin
                blk_lo = blk_hi;
                blk_hi += step;
                if (blk_lo >= n)
                    return 1'b0;
            end
            if (blk_hi > n)
                blk_hi = n;
            for (int unsigned i = blk_lo; i < blk_hi; i++)
            begin
                if (entries[i] == key)
                begin
                    pos = index_t'(i);
                    return 1'b1;
                end
                if (entries[i] > key)
                    return 1'b0;
            end
            return 1'b0;
        endfunction

        // An accepted request: a write updates the table, a search owes a result.
        function void note_request(logic kind, index_t idx, value_t val);
            search_outcome_t outcome;
            if (kind == REQ_WRITE)
                entries[idx] = val;
            else
            begin
                outcome.found = locate_key(val, outcome.position);
                awaited_results.push_back(outcome);
            end
        endfunction

        // An accepted result is matched against the oldest owed outcome.
        function void check_result(logic found, index_t position);
            search_outcome_t oldest;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with no search pending: found=%0d position=%0d",
                             found, position);
                return;
            end
            oldest = awaited_results.pop_front();
            if (oldest.found !== found || oldest.position !== position)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected found=%0d position=%0d, got found=%0d position=%0d",
                             oldest.found, oldest.position, found, position);
            end
        endfunction
    endclass
endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench: drives write and search requests into the jump search block
// and checks every search result. Depends on jsst_pkg, jsst_if.sv and jsst_tb_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jsst_pkg::*;
    import jsst_tb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned RANDOM_ITEMS   = 1300;
    localparam int unsigned PREFIX_REWRITE = 128;
    localparam value_t VALUE_MIN = 32'sh8000_0000;
    localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_LIGHT_BOTH} pace_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_wdata;

    jsst_req_if req_ch ();
    jsst_res_if res_ch ();

    table_search_tracker board;
    pace_t               pace;
    int unsigned         quiet_cycles = 0;
    int unsigned         stim_items;

    jump_search_sorted_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Percentage of cycles in which a side holds back under the current pace.
    function automatic int unsigned gap_percent(bit recv_side);
        case (pace)
            PACE_SEND_GAPS:   return recv_side ? 0 : 59;
            PACE_RECV_STALLS: return recv_side ? 59 : 0;
            PACE_LIGHT_BOTH:  return 7;
            default:          return 0;
        endcase
    endfunction

    // Result side: check accepted results, then pick ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.found, res_ch.position);
        res_ch.ready <= ($urandom_range(99) >= gap_percent(1'b1));
    end

    // Watchdog on cycles in which neither channel moves anything.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one request, with random gaps before it, and wait for acceptance.
    // Valid stays high afterwards so back-to-back requests need no extra edge.
    task automatic send_item(logic kind, index_t idx, value_t val);
        while ($urandom_range(99) < gap_percent(1'b0))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.entry_index <= idx;
        req_ch.item_value  <= val;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        board.note_request(kind, idx, val);
        stim_items++;
    endtask

    // Drop valid, drain every owed result and let a trailing write finish.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (board.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_index_t idx, cfg_data_t data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_register(idx, data);
    endtask

    task automatic configure(cfg_data_t count, cfg_data_t stride);
        settle();
        write_register(CFG_ELEMENT_COUNT, count);
        write_register(CFG_JUMP_STRIDE, stride);
    endtask

    // Rewrite entries 0..n-1 with ascending values, often with duplicate runs.
    task automatic load_sorted_prefix(int unsigned n);
        longint      acc;
        int unsigned roll;
        acc = ($urandom_range(9) == 0) ? longint'(VALUE_MIN) : longint'($signed($urandom)) / 2;
        for (int unsigned i = 0; i < n; i++)
        begin
            send_item(REQ_WRITE, index_t'(i), value_t'(acc));
            roll = $urandom_range(3);
            if (roll == 3)
                acc += $urandom_range(1 << 24);
            else if (roll != 0)
                acc += $urandom_range(1, 8);
            if (acc > longint'(VALUE_MAX))
                acc = VALUE_MAX;
        end
    endtask

    // Search keys: present values most often, some neighbors, extremes and noise.
    function automatic value_t pick_key();
        int unsigned n;
        int unsigned roll;
        value_t      hit_val;
        n = board.used_length();
        roll = $urandom_range(99);
        if (n == 0 || roll < 30)
            return $urandom;
        hit_val = board.entries[$urandom_range(n - 1)];
        if (roll < 75)
            return hit_val;
        if (roll < 90)
            return $urandom_range(1) ? hit_val + 1 : hit_val - 1;
        return (roll < 95) ? VALUE_MIN : VALUE_MAX;
    endfunction

    // Searches with a sprinkling of stray writes that may unsort the table.
    task automatic run_searches(int unsigned n_searches);
        for (int unsigned i = 0; i < n_searches; i++)
        begin
            if ($urandom_range(99) < 8)
                send_item(REQ_WRITE, index_t'($urandom_range(1023)), value_t'($urandom));
            else
                send_item(REQ_SEARCH, index_t'($urandom), pick_key());
        end
    endtask

    // One setting: program it, refresh the table if it is small, then search. Slow probe
    // patterns get fewer searches to keep the run short.
    task automatic run_phase(cfg_data_t count, cfg_data_t stride);
        int unsigned n;
        int unsigned step;
        n = (count > REACH_LIMIT) ? REACH_LIMIT : count;
        step = (stride == 0) ? 1 : stride;
        configure(count, stride);
        if (n <= PREFIX_REWRITE)
            load_sorted_prefix(n);
        run_searches((n / step + step > 200) ? 10 : 40);
    endtask

    initial
    begin
        value_t      seed_vals [8] = '{VALUE_MIN, -5, -5, 0, 7, 7, 7, VALUE_MAX};
        value_t      probe_keys [7] = '{VALUE_MIN, VALUE_MAX, -5, 7, 3, 8, -6};
        cfg_data_t   fixed_counts [14] = '{1024, 1024, 1024, 2047, 1500, 2047, 1, 2, 2,
                                           5, 17, 64, 100, 128};
        cfg_data_t   fixed_strides [14] = '{32, 1, 1024, 45, 0, 2047, 1, 0, 2047,
                                            2, 4, 8, 10, 128};
        int unsigned phase;
        int unsigned pick_n;
        int unsigned root;
        cfg_data_t   count;
        cfg_data_t   stride;

        board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ELEMENT_COUNT;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_WRITE;
        req_ch.entry_index = '0;
        req_ch.item_value = '0;
        pace = PACE_FULL;
        stim_items = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table straight out of reset: every search misses.
        send_item(REQ_SEARCH, '0, '0);
        send_item(REQ_SEARCH, '1, VALUE_MAX);

        // Small table with both extremes and duplicate runs across block edges.
        foreach (seed_vals[i])
            send_item(REQ_WRITE, index_t'(i), seed_vals[i]);
        configure(8, 3);
        foreach (probe_keys[i])
            send_item(REQ_SEARCH, index_t'(i), probe_keys[i]);

        // Zero stride behaves as stride one.
        configure(8, 0);
        send_item(REQ_SEARCH, '0, 0);
        send_item(REQ_SEARCH, '0, VALUE_MIN + 1);

        // Stride far beyond the count: one block clipped to the used length.
        configure(8, 2047);
        send_item(REQ_SEARCH, '0, 7);
        send_item(REQ_SEARCH, '0, VALUE_MAX);

        // Break the ordering and search around the damage.
        send_item(REQ_WRITE, index_t'(3), 100);
        send_item(REQ_SEARCH, '0, 0);
        send_item(REQ_SEARCH, '0, 100);

        // Fill the whole table in ascending order so any count reads only
        // written entries from here on.
        for (int unsigned i = 0; i < REACH_LIMIT; i++)
            send_item(REQ_WRITE, index_t'(i),
                      value_t'(longint'(VALUE_MIN) + longint'(i) * 4194000
                               + $urandom_range(150)));

        // Fixed settings first: large counts while the table is still sorted.
        phase = 0;
        foreach (fixed_counts[i])
        begin
            pace = pace_t'(phase % 4);
            run_phase(fixed_counts[i], fixed_strides[i]);
            phase++;
        end

        // Random settings until the request budget is spent.
        while (stim_items < RANDOM_ITEMS)
        begin
            pace = pace_t'(phase % 4);
            pick_n = $urandom_range(99);
            if (pick_n < 10)
                count = cfg_data_t'($urandom_range(1025, 2047));
            else if (pick_n < 30)
                count = cfg_data_t'($urandom_range(129, 1024));
            else
                count = cfg_data_t'($urandom_range(1, 128));
            pick_n = (count > REACH_LIMIT) ? REACH_LIMIT : count;
            root = 1;
            while ((root + 1) * (root + 1) <= pick_n)
                root++;
            case ($urandom_range(3))
                0:       stride = cfg_data_t'(root);
                1:       stride = cfg_data_t'($urandom_range(1, pick_n));
                2:       stride = cfg_data_t'($urandom_range(2047));
                default: stride = cfg_data_t'(root + 1);
            endcase
            run_phase(count, stride);
            phase++;
        end

        settle();
        if (board.errors == 0 && board.awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/jsst_pkg.sv
rtl/core/jsst_if.sv
rtl/core/jsst_datapath.sv
rtl/core/jsst_ctrl.sv
rtl/core/jump_search_sorted_table_top.sv
tb/sv/jsst_tb_pkg.sv
tb/sv/tb_top.sv
